>>> src/scaled_day_clock_top_macros.svh
// ---------------------------------------------------------------------------
// Scaled day clock assertion macros
// Shared property wrappers, clocked on clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef SCALED_DAY_CLOCK_TOP_MACROS_SVH
`define SCALED_DAY_CLOCK_TOP_MACROS_SVH

// same-cycle implication
`define SDC_ASSERT_NOW(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
    else $error(msg);

// next-cycle implication
`define SDC_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
    else $error(msg);

`endif

>>> src/sdc_pkg.sv
// ---------------------------------------------------------------------------
// Scaled day clock package
// Shared constants, controller/datapath command types and the period decode.
// ---------------------------------------------------------------------------
package sdc_pkg;

  localparam int ELAPSED_W      = 20;
  localparam int CFG_W          = 16;
  localparam int CFG_ADDR_W     = 1;
  localparam int SEC_W          = 6;
  localparam int MIN_W          = 6;
  localparam int HR_W           = 5;
  localparam int ADD_DAYS_W     = 16;
  localparam int PERIOD_W       = 3;

  localparam int MIN_PER_DAY    = 1440;
  localparam int SEC_PER_MIN    = 60;
  localparam int HR_PER_DAY     = 24;

  // elapsed * speed * 1440, units of 2^-24 s
  localparam int MUL_LO_W       = ELAPSED_W + CFG_W;
  localparam int PROD_W         = 47;
  localparam int PROD_FRAC_BITS = 24;
  // whole seconds out of one tick, and operand width of the carry divisions
  localparam int SECS_W         = PROD_W - PROD_FRAC_BITS + 1;
  localparam int CARRY_W        = SECS_W + 1;

  // reciprocals for the 60 and 24 carries, exact for operands below 2^CARRY_W
  localparam int RECIP_W        = 27;
  localparam int RECIP_SHIFT    = 31;
  localparam logic [RECIP_W-1:0] RECIP_60 = 27'd35791395;
  localparam logic [RECIP_W-1:0] RECIP_24 = 27'd89478486;

  localparam logic [CFG_W-1:0] SPEED_RESET   = 16'd256;
  localparam logic [CFG_W-1:0] DAY_LEN_RESET = 16'd20;

  localparam logic [CFG_ADDR_W-1:0] REG_SPEED   = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_DAY_LEN = 1'd1;

  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_ADD  = 1'b1;

  localparam logic [PERIOD_W-1:0] PER_DAWN      = 3'd0;
  localparam logic [PERIOD_W-1:0] PER_MORNING   = 3'd1;
  localparam logic [PERIOD_W-1:0] PER_NOON      = 3'd2;
  localparam logic [PERIOD_W-1:0] PER_AFTERNOON = 3'd3;
  localparam logic [PERIOD_W-1:0] PER_EVENING   = 3'd4;
  localparam logic [PERIOD_W-1:0] PER_DUSK      = 3'd5;
  localparam logic [PERIOD_W-1:0] PER_NIGHT     = 3'd6;

  typedef enum logic [1:0] {
    STAGE_TICK,
    STAGE_SEC,
    STAGE_MIN,
    STAGE_HR
  } div_stage_t;

  typedef struct packed {
    logic       capture;
    logic       mul_lo;
    logic       mul_hi;
    logic       div_load;
    logic       div_step;
    logic       div_finish;
    logic       publish;
    div_stage_t stage;
  } sdc_cmd_t;

  function automatic logic [PERIOD_W-1:0] period_of(input logic [HR_W-1:0] h);
    logic [PERIOD_W-1:0] p;
    if (h inside {[5'd4:5'd5]}) begin
      p = PER_DAWN;
    end else if (h inside {[5'd6:5'd9]}) begin
      p = PER_MORNING;
    end else if (h inside {[5'd10:5'd11]}) begin
      p = PER_NOON;
    end else if (h inside {[5'd12:5'd16]}) begin
      p = PER_AFTERNOON;
    end else if (h inside {[5'd17:5'd19]}) begin
      p = PER_EVENING;
    end else if (h inside {[5'd20:5'd21]}) begin
      p = PER_DUSK;
    end else begin
      p = PER_NIGHT;
    end
    return p;
  endfunction

endpackage

>>> src/scaled_day_clock_top.sv
// Tick items: multiply, day-length division, carries. Add items: carries only.
// Throughput: one item at a time; the next is taken the cycle after the result
// moves to the output register, which frees the block while the result waits.
// The day-length divider is bit-serial, one quotient bit per cycle; each of the
// 60/60/24 carries is a reciprocal multiply run through load, step and finish states.
// Synchronous active-low reset clears the clock and loads speed 256, day length 20.
// ---------------------------------------------------------------------------
// Scaled day clock top level
// Game clock advanced by scaled real time or by a fixed duration.
// ---------------------------------------------------------------------------
module scaled_day_clock_top #(
  parameter int FRACTION_BITS  = 16,
  parameter int DAY_COUNT_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [sdc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [sdc_pkg::CFG_W-1:0]         cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_action,
  input  logic [sdc_pkg::ELAPSED_W-1:0]     in_elapsed,
  input  logic [sdc_pkg::SEC_W-1:0]         in_add_seconds,
  input  logic [sdc_pkg::MIN_W-1:0]         in_add_minutes,
  input  logic [sdc_pkg::HR_W-1:0]          in_add_hours,
  input  logic [sdc_pkg::ADD_DAYS_W-1:0]    in_add_days,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [sdc_pkg::SEC_W-1:0]         out_now_seconds,
  output logic [sdc_pkg::MIN_W-1:0]         out_now_minutes,
  output logic [sdc_pkg::HR_W-1:0]          out_now_hours,
  output logic [DAY_COUNT_BITS-1:0]         out_now_days,
  output logic [sdc_pkg::PERIOD_W-1:0]      out_period
);

  sdc_pkg::sdc_cmd_t cmd;
  logic              div_last;

  sdc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_action (in_action),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .div_last  (div_last),
    .cmd       (cmd)
  );

  sdc_dpath #(
    .FRACTION_BITS  (FRACTION_BITS),
    .DAY_COUNT_BITS (DAY_COUNT_BITS)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .div_last        (div_last),
    .cfg_we          (cfg_we),
    .cfg_addr        (cfg_addr),
    .cfg_wdata       (cfg_wdata),
    .in_action       (in_action),
    .in_elapsed      (in_elapsed),
    .in_add_seconds  (in_add_seconds),
    .in_add_minutes  (in_add_minutes),
    .in_add_hours    (in_add_hours),
    .in_add_days     (in_add_days),
    .out_now_seconds (out_now_seconds),
    .out_now_minutes (out_now_minutes),
    .out_now_hours   (out_now_hours),
    .out_now_days    (out_now_days),
    .out_period      (out_period)
  );

endmodule

>>> src/sdc_ctrl.sv
// ---------------------------------------------------------------------------
// Scaled day clock controller
// Sequences capture, the two multiply steps and four divider passes of a tick
// item or the three carry passes of an add item, and the handoff to the output register.
// ---------------------------------------------------------------------------
module sdc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_action,
  output logic              out_valid,
  input  logic              out_ready,
  input  logic              div_last,
  output sdc_pkg::sdc_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_LO,
    S_MUL_HI,
    S_LOAD,
    S_STEP,
    S_FIN,
    S_PUB
  } state_t;

  state_t              state_r, state_nxt;
  sdc_pkg::div_stage_t stage_r, stage_nxt;
  logic                out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    stage_nxt     = stage_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.stage     = stage_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (in_action == sdc_pkg::ACT_ADD) begin
            stage_nxt = sdc_pkg::STAGE_SEC;
            state_nxt = S_LOAD;
          end else begin
            state_nxt = S_MUL_LO;
          end
        end
      end
      S_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = S_MUL_HI;
      end
      S_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        stage_nxt  = sdc_pkg::STAGE_TICK;
        state_nxt  = S_LOAD;
      end
      S_LOAD: begin
        cmd.div_load = 1'b1;
        state_nxt    = S_STEP;
      end
      S_STEP: begin
        cmd.div_step = 1'b1;
        if (div_last) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.div_finish = 1'b1;
        case (stage_r)
          sdc_pkg::STAGE_TICK: begin
            stage_nxt = sdc_pkg::STAGE_SEC;
            state_nxt = S_LOAD;
          end
          sdc_pkg::STAGE_SEC: begin
            stage_nxt = sdc_pkg::STAGE_MIN;
            state_nxt = S_LOAD;
          end
          sdc_pkg::STAGE_MIN: begin
            stage_nxt = sdc_pkg::STAGE_HR;
            state_nxt = S_LOAD;
          end
          default: begin
            state_nxt = S_PUB;
          end
        endcase
      end
      S_PUB: begin
        if (!out_valid_r || out_ready) begin
          cmd.publish   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      stage_r     <= sdc_pkg::STAGE_TICK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      stage_r     <= stage_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> src/sdc_dpath.sv
// ---------------------------------------------------------------------------
// Scaled day clock datapath
// Config registers, two-step scaling multiply, bit-serial restoring divider
// for the day length, reciprocal multiply for the 60/60/24 carries, clock
// state and the output register.
// ---------------------------------------------------------------------------
module sdc_dpath #(
  parameter int FRACTION_BITS  = 16,
  parameter int DAY_COUNT_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  sdc_pkg::sdc_cmd_t                 cmd,
  output logic                              div_last,
  input  logic                              cfg_we,
  input  logic [sdc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [sdc_pkg::CFG_W-1:0]         cfg_wdata,
  input  logic                              in_action,
  input  logic [sdc_pkg::ELAPSED_W-1:0]     in_elapsed,
  input  logic [sdc_pkg::SEC_W-1:0]         in_add_seconds,
  input  logic [sdc_pkg::MIN_W-1:0]         in_add_minutes,
  input  logic [sdc_pkg::HR_W-1:0]          in_add_hours,
  input  logic [sdc_pkg::ADD_DAYS_W-1:0]    in_add_days,
  output logic [sdc_pkg::SEC_W-1:0]         out_now_seconds,
  output logic [sdc_pkg::MIN_W-1:0]         out_now_minutes,
  output logic [sdc_pkg::HR_W-1:0]          out_now_hours,
  output logic [DAY_COUNT_BITS-1:0]         out_now_days,
  output logic [sdc_pkg::PERIOD_W-1:0]      out_period
);

  // quotient width of the day-length division
  localparam int QW    = sdc_pkg::PROD_W - sdc_pkg::PROD_FRAC_BITS + FRACTION_BITS;
  localparam int CNT_W = $clog2(QW + 1);
  localparam int CW    = sdc_pkg::CARRY_W;
  localparam int DW    = sdc_pkg::CFG_W;
  localparam int PW    = CW + sdc_pkg::RECIP_W;

  logic [DW-1:0]                     speed_r, day_len_r;

  logic [sdc_pkg::ELAPSED_W-1:0]     elapsed_r;
  logic [sdc_pkg::MUL_LO_W-1:0]      prod_lo_r;
  logic [sdc_pkg::PROD_W-1:0]        prod_r;

  logic [sdc_pkg::SECS_W-1:0]        sec_add_r;
  logic [sdc_pkg::MIN_W-1:0]         min_add_r;
  logic [sdc_pkg::HR_W-1:0]          hr_add_r;
  logic [sdc_pkg::ADD_DAYS_W-1:0]    day_add_r;
  logic [CW-1:0]                     carry_r;
  logic [CW-1:0]                     cx_r;

  logic [QW-1:0]                     quo_r;
  logic [DW-1:0]                     rem_r;
  logic [DW-1:0]                     dvsr_r;
  logic [CNT_W-1:0]                  cnt_r;

  logic [FRACTION_BITS-1:0]          frac_r;
  logic [sdc_pkg::SEC_W-1:0]         sec_r;
  logic [sdc_pkg::MIN_W-1:0]         min_r;
  logic [sdc_pkg::HR_W-1:0]          hr_r;
  logic [DAY_COUNT_BITS-1:0]         days_r;

  logic [sdc_pkg::SEC_W-1:0]         out_sec_r;
  logic [sdc_pkg::MIN_W-1:0]         out_min_r;
  logic [sdc_pkg::HR_W-1:0]          out_hr_r;
  logic [DAY_COUNT_BITS-1:0]         out_days_r;
  logic [sdc_pkg::PERIOD_W-1:0]      out_period_r;

  logic [DW:0]                       rem_ext;
  logic                              rem_ge;
  logic [DW:0]                       rem_sub;
  logic [CW-1:0]                     carry_val;
  logic [QW:0]                       acc;
  logic [sdc_pkg::RECIP_W-1:0]       recip;
  logic [PW-1:0]                     cprod;
  logic [CW-1:0]                     cq;
  logic [CW-1:0]                     cmul;
  logic [CW-1:0]                     crem;

  assign rem_ext  = {rem_r, quo_r[QW-1]};
  assign rem_ge   = (rem_ext >= {1'b0, dvsr_r});
  assign rem_sub  = rem_ext - {1'b0, dvsr_r};
  assign div_last = (cnt_r == CNT_W'(1));
  assign acc      = (QW + 1)'(frac_r) + (QW + 1)'(quo_r);

  // carry quotient by reciprocal multiply, remainder once the quotient is registered
  assign recip = (cmd.stage == sdc_pkg::STAGE_HR) ? sdc_pkg::RECIP_24 : sdc_pkg::RECIP_60;
  assign cprod = PW'(cx_r) * PW'(recip);
  assign cq    = CW'(cprod[PW-1:sdc_pkg::RECIP_SHIFT]);
  assign cmul  = (cmd.stage == sdc_pkg::STAGE_HR) ? quo_r[CW-1:0] * CW'(sdc_pkg::HR_PER_DAY)
                                                  : quo_r[CW-1:0] * CW'(sdc_pkg::SEC_PER_MIN);
  assign crem  = cx_r - cmul;

  always_comb begin
    case (cmd.stage)
      sdc_pkg::STAGE_SEC: carry_val = CW'(sec_r) + CW'(sec_add_r);
      sdc_pkg::STAGE_MIN: carry_val = CW'(min_r) + CW'(min_add_r) + carry_r;
      sdc_pkg::STAGE_HR:  carry_val = CW'(hr_r) + CW'(hr_add_r) + carry_r;
      default:            carry_val = '0;
    endcase
  end

  // config and clock state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r   <= sdc_pkg::SPEED_RESET;
      day_len_r <= sdc_pkg::DAY_LEN_RESET;
      frac_r    <= '0;
      sec_r     <= '0;
      min_r     <= '0;
      hr_r      <= '0;
      days_r    <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          sdc_pkg::REG_SPEED:   speed_r   <= cfg_wdata;
          sdc_pkg::REG_DAY_LEN: day_len_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.div_finish) begin
        case (cmd.stage)
          sdc_pkg::STAGE_TICK: frac_r <= acc[FRACTION_BITS-1:0];
          sdc_pkg::STAGE_SEC:  sec_r  <= crem[sdc_pkg::SEC_W-1:0];
          sdc_pkg::STAGE_MIN:  min_r  <= crem[sdc_pkg::MIN_W-1:0];
          sdc_pkg::STAGE_HR: begin
            hr_r   <= crem[sdc_pkg::HR_W-1:0];
            days_r <= days_r + DAY_COUNT_BITS'(day_add_r)
                      + DAY_COUNT_BITS'(quo_r[CW-1:0]);
          end
          default: ;
        endcase
      end
    end
  end

  // operands, multiply, divider
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      elapsed_r <= in_elapsed;
      if (in_action == sdc_pkg::ACT_ADD) begin
        sec_add_r <= sdc_pkg::SECS_W'(in_add_seconds);
        min_add_r <= in_add_minutes;
        hr_add_r  <= in_add_hours;
        day_add_r <= in_add_days;
      end else begin
        sec_add_r <= '0;
        min_add_r <= '0;
        hr_add_r  <= '0;
        day_add_r <= '0;
      end
    end
    if (cmd.mul_lo) begin
      prod_lo_r <= sdc_pkg::MUL_LO_W'(elapsed_r) * sdc_pkg::MUL_LO_W'(speed_r);
    end
    if (cmd.mul_hi) begin
      prod_r <= sdc_pkg::PROD_W'(prod_lo_r) * sdc_pkg::PROD_W'(sdc_pkg::MIN_PER_DAY);
    end
    if (cmd.div_load) begin
      rem_r <= '0;
      if (cmd.stage == sdc_pkg::STAGE_TICK) begin
        quo_r  <= prod_r[sdc_pkg::PROD_W-1:sdc_pkg::PROD_FRAC_BITS-FRACTION_BITS];
        dvsr_r <= (day_len_r == '0) ? DW'(1) : day_len_r;
        cnt_r  <= CNT_W'(QW);
      end else begin
        // one multiply step for a carry
        cx_r  <= carry_val;
        cnt_r <= CNT_W'(1);
      end
    end
    if (cmd.div_step) begin
      if (cmd.stage == sdc_pkg::STAGE_TICK) begin
        rem_r <= rem_ge ? rem_sub[DW-1:0] : rem_ext[DW-1:0];
        quo_r <= {quo_r[QW-2:0], rem_ge};
      end else begin
        quo_r <= QW'(cq);
      end
      cnt_r <= cnt_r - CNT_W'(1);
    end
    if (cmd.div_finish) begin
      if (cmd.stage == sdc_pkg::STAGE_TICK) begin
        sec_add_r <= acc[QW:FRACTION_BITS];
      end else begin
        carry_r <= quo_r[CW-1:0];
      end
    end
    if (cmd.publish) begin
      out_sec_r    <= sec_r;
      out_min_r    <= min_r;
      out_hr_r     <= hr_r;
      out_days_r   <= days_r;
      out_period_r <= sdc_pkg::period_of(hr_r);
    end
  end

  assign out_now_seconds = out_sec_r;
  assign out_now_minutes = out_min_r;
  assign out_now_hours   = out_hr_r;
  assign out_now_days    = out_days_r;
  assign out_period      = out_period_r;

endmodule

>>> src/sdc_checker.sv
// ---------------------------------------------------------------------------
// Scaled day clock checker
// Port-level checks on result ranges, period decode and item sequencing.
// ---------------------------------------------------------------------------
`include "scaled_day_clock_top_macros.svh"

module sdc_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [sdc_pkg::SEC_W-1:0]     out_now_seconds,
  input  logic [sdc_pkg::MIN_W-1:0]     out_now_minutes,
  input  logic [sdc_pkg::HR_W-1:0]      out_now_hours,
  input  logic [sdc_pkg::PERIOD_W-1:0]  out_period
);

  `SDC_ASSERT_NOW(a_time_range, out_valid, (out_now_seconds < 6'd60) && (out_now_minutes < 6'd60) && (out_now_hours < 5'd24), "result time out of range")

  `SDC_ASSERT_NOW(a_period_decode, out_valid, out_period == sdc_pkg::period_of(out_now_hours), "period does not match hour")

  `SDC_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "second item taken while one is in work")

  `SDC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_now_seconds) && $stable(out_period), "stalled result changed")

endmodule

bind scaled_day_clock_top sdc_checker u_sdc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_now_seconds (out_now_seconds),
  .out_now_minutes (out_now_minutes),
  .out_now_hours   (out_now_hours),
  .out_period      (out_period)
);
